### rtl/ring_buffer_fifo_top_defines.svh
// Assertion macros shared by the ring buffer FIFO checker.
`ifndef RING_BUFFER_FIFO_TOP_DEFINES_SVH
`define RING_BUFFER_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RBF_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("rbf check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RBF_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("rbf check failed");

`endif

### rtl/rbf_pkg.sv
// Shared types, constants and helpers for the ring buffer FIFO.
`timescale 1ns / 1ps

package rbf_pkg;

    // Storage geometry.
    localparam int PTR_W   = 6;
    localparam int DEPTH   = 1 << PTR_W;
    localparam int ELEM_W  = 32;
    localparam int SIZE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Function codes of an input beat.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PEEK  = 2'd2;

    // Register indexes.
    localparam logic REG_SIZE_POWER = 1'b0;

    // Reset value of the size register.
    localparam logic [SIZE_W-1:0] SIZE_POWER_RESET = SIZE_W'(PTR_W);

    typedef struct packed {
        logic [1:0]        func;
        logic [ELEM_W-1:0] element_in;
        logic [PTR_W-1:0]  request_count;
    } in_item_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element_out;
        logic              has_element;
        logic              is_last;
        logic              accepted;
        logic [PTR_W-1:0]  granted_count;
        logic [PTR_W-1:0]  space_left;
        logic [PTR_W-1:0]  data_left;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_BURST,
        CMD_EMPTY
    } cmd_kind_t;

    // One classified item, handed from the front to the back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ELEM_W-1:0] data;
        logic [PTR_W-1:0]  waddr;
        logic [PTR_W-1:0]  start;
        logic [PTR_W-1:0]  mask;
        logic [PTR_W-1:0]  granted;
        logic              accepted;
        logic [PTR_W-1:0]  space_left;
        logic [PTR_W-1:0]  data_left;
    } cmd_t;

    // Configuration write request as seen by the front.
    typedef struct packed {
        logic              psel;
        logic              penable;
        logic              pwrite;
        logic [ADDR_W-1:0] paddr;
        logic [DATA_W-1:0] pwdata;
    } cfg_req_t;

    // Pointer mask for a size register value. Zero acts as one, and values
    // beyond the storage act as the full storage.
    function automatic logic [PTR_W-1:0] ring_mask(input logic [SIZE_W-1:0] p);
        logic [SIZE_W-1:0] p_eff;
        logic [PTR_W-1:0]  m;
        p_eff = (p == '0) ? SIZE_W'(1) : p;
        if (int'(p_eff) >= PTR_W) begin
            m = '1;
        end
        else begin
            m = PTR_W'((1 << p_eff) - 1);
        end
        return m;
    endfunction

endpackage

### rtl/rbf_front.sv
// Front end: owns the pointers and size, accepts and classifies input beats.
`timescale 1ns / 1ps

module rbf_front
    import rbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  in_item_t            item,
    input  cfg_req_t            cfg,
    output logic [DATA_W-1:0]   prdata,
    output logic                cmd_valid,
    input  logic                cmd_full,
    output cmd_t                cmd
);

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic              accept;
    logic              cfg_write;
    logic [PTR_W-1:0]  mask;
    logic [PTR_W-1:0]  new_mask;
    logic [PTR_W-1:0]  stored;
    logic [PTR_W-1:0]  stored_after;
    logic [PTR_W-1:0]  granted;

    // The queue decides whether a beat can be taken.
    assign item_stall = cmd_full;
    assign accept     = item_valid && !cmd_full;
    assign cmd_valid  = accept;

    assign cfg_write = cfg.psel && cfg.penable && cfg.pwrite
                       && (cfg.paddr[2] == REG_SIZE_POWER);

    // Register read-back.
    assign prdata = (cfg.paddr[2] == REG_SIZE_POWER)
                    ? DATA_W'(size_reg) : '0;

    assign mask     = ring_mask(size_reg);
    assign new_mask = ring_mask(cfg.pwdata[SIZE_W-1:0]);
    assign stored   = (wp_reg - rp_reg) & mask;
    assign granted  = (item.request_count < stored) ? item.request_count : stored;

    // Classify the beat and work out the pointer updates.
    always_comb
    begin
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        size_next    = size_reg;
        stored_after = stored;
        cmd          = '0;
        cmd.kind     = CMD_EMPTY;
        cmd.data     = item.element_in;
        cmd.waddr    = wp_reg;
        cmd.start    = rp_reg;
        cmd.mask     = mask;

        if (cfg_write) begin
            size_next = cfg.pwdata[SIZE_W-1:0];
            rp_next   = rp_reg & new_mask;
            wp_next   = wp_reg & new_mask;
        end
        else if (accept) begin
            unique case (item.func) inside
                FUNC_WRITE:
                begin
                    cmd.kind = CMD_WRITE;
                    if (stored != mask) begin
                        cmd.accepted = 1'b1;
                        wp_next      = (wp_reg + PTR_W'(1)) & mask;
                        stored_after = stored + PTR_W'(1);
                    end
                end
                FUNC_READ, FUNC_PEEK:
                begin
                    cmd.granted = granted;
                    if (granted != '0) begin
                        cmd.kind = CMD_BURST;
                    end
                    if (item.func == FUNC_READ) begin
                        rp_next      = (rp_reg + granted) & mask;
                        stored_after = stored - granted;
                    end
                end
                default:
                begin
                    cmd.kind = CMD_EMPTY;
                end
            endcase
        end

        cmd.data_left  = stored_after;
        cmd.space_left = mask - stored_after;
    end

    // Pointer and size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            size_reg <= SIZE_POWER_RESET;
        end
        else begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            size_reg <= size_next;
        end
    end

endmodule

### rtl/rbf_cmd_queue.sv
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps

module rbf_cmd_queue
    import rbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count updates; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1)
                          ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1)
                          ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/rbf_back.sv
// Back end: slot memory, burst sequencing and the result output register.
`timescale 1ns / 1ps

module rbf_back
    import rbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic [ELEM_W-1:0] mem_reg [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic              pend_valid_reg, pend_valid_next;
    out_item_t         pend_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg;

    logic              out_free;
    logic              issue;
    logic              is_burst;
    logic              last_of_cmd;
    logic [PTR_W-1:0]  rd_addr;
    out_item_t         issue_meta;

    assign out_free    = !out_valid_reg || !result_stall;
    assign issue       = cmd_valid && (!pend_valid_reg || out_free);
    assign is_burst    = (cmd.kind == CMD_BURST);
    assign last_of_cmd = !is_burst || (idx_reg == cmd.granted - PTR_W'(1));
    assign cmd_pop     = issue && last_of_cmd;
    assign rd_addr     = (cmd.start + idx_reg) & cmd.mask;

    // Result fields known at issue time; the element follows from memory.
    always_comb
    begin
        issue_meta               = '0;
        issue_meta.has_element   = is_burst;
        issue_meta.is_last       = last_of_cmd;
        issue_meta.accepted      = cmd.accepted;
        issue_meta.granted_count = cmd.granted;
        issue_meta.space_left    = cmd.space_left;
        issue_meta.data_left     = cmd.data_left;
    end

    // Burst index and stage valid bits.
    always_comb
    begin
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (out_free) begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
        if (issue) begin
            pend_valid_next = 1'b1;
            idx_next        = last_of_cmd ? '0 : idx_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Single-port slot memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (issue && (cmd.kind == CMD_WRITE) && cmd.accepted) begin
            mem_reg[cmd.waddr] <= cmd.data;
        end
        else if (issue && is_burst) begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    // Pending stage and output register payload.
    always_ff @(posedge clk)
    begin
        if (out_free) begin
            out_reg             <= pend_reg;
            out_reg.element_out <= pend_reg.has_element ? rdata_reg : '0;
        end
        if (issue) begin
            pend_reg <= issue_meta;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/ring_buffer_fifo_top.sv
// Top level of the power-of-two ring buffer FIFO.
//
//   Channel   Direction  Payload      Handshake
//   item      in         in_item_t    item_valid / item_stall
//   result    out        out_item_t   result_valid / result_stall
//   config    in         size_power   APB write, pready always high
//
// A write, an empty grant or an unknown function gives one result beat; a read or
// peek gives one beat per granted element, one per cycle unless stalled, limited
// by the single port of the slot memory. The first result passes the queue,
// pending stage and output register. Reset clears the pointers and sets the ring
// to the full 64 slots; slot contents are not cleared. A stalled result holds in
// the output register while the command queue keeps taking beats until full.
`timescale 1ns / 1ps

module ring_buffer_fifo_top
    import rbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  in_item_t          item,
    output logic              result_valid,
    input  logic              result_stall,
    output out_item_t         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_req_t cfg;
    logic     push;
    cmd_t     push_cmd;
    logic     q_full;
    logic     pop;
    logic     head_valid;
    cmd_t     head_cmd;

    assign pready = 1'b1;

    // Gather the configuration request.
    always_comb
    begin
        cfg.psel    = psel;
        cfg.penable = penable;
        cfg.pwrite  = pwrite;
        cfg.paddr   = paddr;
        cfg.pwdata  = pwdata;
    end

    rbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg),
        .prdata     (prdata),
        .cmd_valid  (push),
        .cmd_full   (q_full),
        .cmd        (push_cmd)
    );

    rbf_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rbf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/rbf_checker.sv
// Port-level checker for the ring buffer FIFO, bound to the top level.
`timescale 1ns / 1ps
`include "ring_buffer_fifo_top_defines.svh"

module rbf_checker
    import rbf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    // A stalled result beat stays put.
    `RBF_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(result))

    // A beat without an element carries a zero element.
    `RBF_ASSERT_NOW(a_zero_elem, result_valid && !result.has_element, result.element_out == '0)

    // An element beat belongs to a nonempty grant and never to a write.
    `RBF_ASSERT_NOW(a_elem_grant, result_valid && result.has_element, (result.granted_count != '0) && !result.accepted)

    // Free space and stored count never add up past the largest ring.
    `RBF_ASSERT_NOW(a_fill_sum, result_valid, ({1'b0, result.space_left} + {1'b0, result.data_left}) <= 7'd63)

endmodule

bind ring_buffer_fifo_top rbf_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### dv/tb_ring_buffer_fifo_top.sv
// Self-checking testbench for the ring buffer FIFO top level.
`timescale 1ns / 1ps

module tb_ring_buffer_fifo_top;
    import rbf_pkg::*;

    // Function code with no defined operation.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 20;
    localparam int NUM_PHASES     = 10;
    localparam int FILL_PHASE     = 8;
    localparam int PHASE_ITEMS    = 14;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    in_item_t          item_beat    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    out_item_t         result_beat;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow copy of the buffer contents, pointers and size register.
    logic [ELEM_W-1:0] slot_shadow [DEPTH];
    bit                slot_written [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_shadow = '0;
    logic [PTR_W-1:0]  wr_ptr_shadow = '0;
    logic [SIZE_W-1:0] size_shadow   = SIZE_POWER_RESET;

    in_item_t    pending_items [$];
    out_item_t   expected_beats [$];
    out_item_t   want_beat;
    int unsigned fail_count   = 0;
    bit          idle_on      = 1'b1;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;

    ring_buffer_fifo_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pointer mask of the ring in use; zero acts as two slots, oversize as the full store.
    function automatic logic [PTR_W-1:0] ring_mask_of(input logic [SIZE_W-1:0] p);
        logic [PTR_W-1:0] m;
        if (p == '0)
        begin
            m = PTR_W'(1);
        end
        else if (int'(p) >= PTR_W)
        begin
            m = '1;
        end
        else
        begin
            m = {PTR_W{1'b1}} >> (PTR_W - int'(p));
        end
        return m;
    endfunction

    // Result beat carrying only the occupancy after the item.
    function automatic out_item_t occupancy_beat(input logic [PTR_W-1:0] m);
        out_item_t        b;
        logic [PTR_W-1:0] cnt;
        cnt = (wr_ptr_shadow - rd_ptr_shadow) & m;
        b = '0;
        b.is_last    = 1'b1;
        b.space_left = m - cnt;
        b.data_left  = cnt;
        return b;
    endfunction

    // Apply one accepted item to the shadow state and queue the beats it causes.
    function automatic void fifo_predict(input in_item_t it);
        logic [PTR_W-1:0] m;
        logic [PTR_W-1:0] cnt;
        logic [PTR_W-1:0] grant;
        logic [PTR_W-1:0] base;
        logic             stored;
        out_item_t        b;
        m = ring_mask_of(size_shadow);
        cnt = (wr_ptr_shadow - rd_ptr_shadow) & m;
        case (it.func) inside
            FUNC_WRITE:
            begin
                stored = 1'b0;
                if (cnt < m)
                begin
                    slot_shadow[wr_ptr_shadow] = it.element_in;
                    slot_written[wr_ptr_shadow] = 1'b1;
                    wr_ptr_shadow = (wr_ptr_shadow + PTR_W'(1)) & m;
                    stored = 1'b1;
                end
                b = occupancy_beat(m);
                b.accepted = stored;
                expected_beats.push_back(b);
            end
            FUNC_READ, FUNC_PEEK:
            begin
                grant = (it.request_count < cnt) ? it.request_count : cnt;
                base = rd_ptr_shadow;
                if (it.func == FUNC_READ)
                begin
                    rd_ptr_shadow = (rd_ptr_shadow + grant) & m;
                end
                b = occupancy_beat(m);
                if (grant == '0)
                begin
                    expected_beats.push_back(b);
                end
                else
                begin
                    b.has_element   = 1'b1;
                    b.granted_count = grant;
                    for (int i = 0; i < int'(grant); i++)
                    begin
                        b.element_out = slot_shadow[(base + PTR_W'(i)) & m];
                        b.is_last     = (i == int'(grant) - 1);
                        expected_beats.push_back(b);
                    end
                end
            end
            default:
            begin
                expected_beats.push_back(occupancy_beat(m));
            end
        endcase
    endfunction

    // True when a resize would expose no slot that was never written.
    function automatic bit resize_is_safe(input logic [SIZE_W-1:0] p);
        logic [PTR_W-1:0] m;
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] cnt;
        bit               ok;
        m = ring_mask_of(p);
        rp = rd_ptr_shadow & m;
        cnt = ((wr_ptr_shadow & m) - rp) & m;
        ok = 1'b1;
        for (int i = 0; i < int'(cnt); i++)
        begin
            if (!slot_written[(rp + PTR_W'(i)) & m])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] f, input logic [ELEM_W-1:0] e,
                                           input logic [PTR_W-1:0] n);
        in_item_t it;
        it.func          = f;
        it.element_in    = e;
        it.request_count = n;
        return it;
    endfunction

    // Writes most often, then reads and peeks with mostly small counts, a few odd codes.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        it.element_in = $urandom();
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            it.request_count = '0;
        end
        else if (pick == 1)
        begin
            it.request_count = '1;
        end
        else if (pick == 2)
        begin
            it.request_count = PTR_W'($urandom_range(0, 63));
        end
        else
        begin
            it.request_count = PTR_W'($urandom_range(1, 4));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            it.func = FUNC_UNUSED;
        end
        else if (pick < 10)
        begin
            it.func = FUNC_WRITE;
        end
        else if (pick < 15)
        begin
            it.func = FUNC_READ;
        end
        else
        begin
            it.func = FUNC_PEEK;
        end
        return it;
    endfunction

    task automatic report_failure(input string msg);
        if (fail_count < MAX_REPORTS)
        begin
            $display("%s", msg);
        end
        fail_count++;
    endtask

    // Block until every queued item is taken and every expected beat has come.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0);
    endtask

    // Drain, empty the ring if the resize is unsafe, then write the size register while idle.
    task automatic set_ring_size(input logic [SIZE_W-1:0] p);
        wait_drained();
        if (!resize_is_safe(p))
        begin
            pending_items.push_back(make_item(FUNC_READ, '0, '1));
            wait_drained();
        end
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(REG_SIZE_POWER));
        pwdata  <= DATA_W'(p);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_shadow   = p;
        rd_ptr_shadow = rd_ptr_shadow & ring_mask_of(p);
        wr_ptr_shadow = wr_ptr_shadow & ring_mask_of(p);
        @(negedge clk);
    endtask

    // Item driver: predicts on each accepted beat, then presents the next pending item.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                fifo_predict(item_beat);
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_beat  <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                    begin
                        gap_left = $urandom_range(1, 4);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_failure($sformatf("unexpected result beat %h", result_beat));
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (result_beat.element_out !== want_beat.element_out
                        || result_beat.has_element !== want_beat.has_element
                        || result_beat.is_last !== want_beat.is_last
                        || result_beat.accepted !== want_beat.accepted
                        || result_beat.granted_count !== want_beat.granted_count
                        || result_beat.space_left !== want_beat.space_left
                        || result_beat.data_left !== want_beat.data_left)
                    begin
                        report_failure($sformatf("result mismatch: expected %h got %h",
                                                 want_beat, result_beat));
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == WATCHDOG_LIMIT - 1)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        logic [SIZE_W-1:0] phase_size [NUM_PHASES];
        phase_size = '{3'd1, 3'd0, 3'd6, 3'd3, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty grants, the unused code, and writes with extreme elements.
        pending_items.push_back(make_item(FUNC_READ, '0, 6'd5));
        pending_items.push_back(make_item(FUNC_PEEK, '1, '0));
        pending_items.push_back(make_item(FUNC_UNUSED, '1, '1));
        pending_items.push_back(make_item(FUNC_WRITE, '0, '1));
        pending_items.push_back(make_item(FUNC_WRITE, '1, '0));
        pending_items.push_back(make_item(FUNC_WRITE, 32'hA5A5_A5A5, 6'h2A));
        pending_items.push_back(make_item(FUNC_WRITE, 32'h5A5A_5A5A, 6'h15));
        // Sender holds off until the block has answered everything so far.
        wait_drained();
        // Zero request with data present, then peeks and reads that wrap the count.
        pending_items.push_back(make_item(FUNC_PEEK, '0, '0));
        pending_items.push_back(make_item(FUNC_PEEK, '0, '1));
        pending_items.push_back(make_item(FUNC_READ, '0, 6'd1));
        pending_items.push_back(make_item(FUNC_PEEK, '0, 6'd2));
        pending_items.push_back(make_item(FUNC_READ, '0, '1));
        pending_items.push_back(make_item(FUNC_READ, '0, 6'd3));
        pending_items.push_back(make_item(FUNC_WRITE, $urandom(), '0));
        pending_items.push_back(make_item(FUNC_READ, '0, '1));

        // Smallest ring: a second write finds it full.
        set_ring_size(3'd1);
        pending_items.push_back(make_item(FUNC_WRITE, $urandom(), '0));
        pending_items.push_back(make_item(FUNC_WRITE, $urandom(), '0));
        pending_items.push_back(make_item(FUNC_PEEK, '0, '1));
        pending_items.push_back(make_item(FUNC_READ, '0, '1));

        // Phases over several ring sizes, random but for the fill phase; phase 3 and the last two run without idling.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph != 3) && (ph < NUM_PHASES - 2);
            set_ring_size(phase_size[ph]);
            if (ph == FILL_PHASE)
            begin
                // Overfill the full ring, then take everything out in one burst.
                repeat (DEPTH) pending_items.push_back(make_item(FUNC_WRITE, $urandom(), '0));
                pending_items.push_back(make_item(FUNC_PEEK, '0, '1));
                pending_items.push_back(make_item(FUNC_READ, '0, '1));
            end
            else
            begin
                repeat (PHASE_ITEMS) pending_items.push_back(random_item());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_beats.size() != 0)
        begin
            report_failure($sformatf("%0d expected result beats never arrived",
                                     expected_beats.size()));
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
